[hdl/nand_bad_block_skip_map_unit_defines.svh]
// Assertion macros shared by the bad block skip map modules.
`ifndef NAND_BAD_BLOCK_SKIP_MAP_UNIT_DEFINES_SVH
`define NAND_BAD_BLOCK_SKIP_MAP_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define NBBSM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("nbbsm: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NBBSM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("nbbsm: next-cycle check failed");

`else

`define NBBSM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define NBBSM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

[hdl/nbbsm_pkg.sv]
// Shared types, codes and helpers of the bad block skip map.
package nbbsm_pkg;

	localparam int DEF_MAX_BLOCKS = 4096;
	localparam int ADDR_SPAN      = 4096;
	localparam int WORD_BITS      = 64;
	localparam int BLK_W          = 12;
	localparam int CFG_W          = 13;
	localparam int CNT_W          = 7;
	localparam int Q_DEPTH        = 2;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_MAP   = 2'd1;
	localparam logic [1:0] OP_NEXT  = 2'd2;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_SCAN,
		CMD_FAIL
	} cmd_kind_t;

	// blk: block to mark, or physical start block of a scan
	// rank: number of good blocks to skip before the one wanted
	typedef struct packed {
		cmd_kind_t        kind;
		logic [BLK_W-1:0] blk;
		logic [BLK_W-1:0] rank;
		logic             mark;
	} cmd_t;

	typedef struct packed {
		logic             found;
		logic [BLK_W-1:0] phys;
	} res_t;

	function automatic logic [CNT_W-1:0] popcnt64(input logic [WORD_BITS-1:0] v);
		logic [CNT_W-1:0] s;
		s = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			s = s + CNT_W'(v[i]);
		end
		return s;
	endfunction

endpackage

[hdl/nbbsm_front.sv]
// Front stage: accept input items and turn them into scan, write or fail commands.
module nbbsm_front #(
	parameter int MAX_BLOCKS = nbbsm_pkg::DEF_MAX_BLOCKS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     in_op,
	input  logic [nbbsm_pkg::BLK_W-1:0]    in_blk,
	input  logic                           in_mark,
	input  logic [nbbsm_pkg::CFG_W-1:0]    lim,
	output logic                           push,
	input  logic                           push_ready,
	output nbbsm_pkg::cmd_t                cmd
);

	logic            vld_s1;
	nbbsm_pkg::cmd_t cmd_s1;
	nbbsm_pkg::cmd_t cls;
	logic            accept;
	logic [nbbsm_pkg::CFG_W-1:0] next_start;

	assign in_ready   = !vld_s1 || push_ready;
	assign accept     = in_valid && in_ready;
	assign push       = vld_s1;
	assign cmd        = cmd_s1;
	assign next_start = nbbsm_pkg::CFG_W'(in_blk) + nbbsm_pkg::CFG_W'(1);

	always_comb begin
		cls.kind = nbbsm_pkg::CMD_FAIL;
		cls.blk  = in_blk;
		cls.rank = '0;
		cls.mark = in_mark;
		case (in_op)
			nbbsm_pkg::OP_WRITE: begin
				if (32'(in_blk) < 32'(MAX_BLOCKS)) begin
					cls.kind = nbbsm_pkg::CMD_WRITE;
				end
			end
			nbbsm_pkg::OP_MAP: begin
				// walk from block 0, skipping blk good blocks
				if (nbbsm_pkg::CFG_W'(in_blk) < lim) begin
					cls.kind = nbbsm_pkg::CMD_SCAN;
					cls.blk  = '0;
					cls.rank = in_blk;
				end
			end
			nbbsm_pkg::OP_NEXT: begin
				if (next_start < lim) begin
					cls.kind = nbbsm_pkg::CMD_SCAN;
					cls.blk  = next_start[nbbsm_pkg::BLK_W-1:0];
				end
			end
			default: begin
				cls.kind = nbbsm_pkg::CMD_FAIL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

endmodule

[hdl/nbbsm_queue.sv]
// Short command queue between the front stage and the map engine.
`include "nand_bad_block_skip_map_unit_defines.svh"

module nbbsm_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            push_ready,
	input  nbbsm_pkg::cmd_t push_cmd,
	output logic            pop_valid,
	input  logic            pop,
	output nbbsm_pkg::cmd_t pop_cmd
);

	localparam int PTR_W = (nbbsm_pkg::Q_DEPTH > 1) ? $clog2(nbbsm_pkg::Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(nbbsm_pkg::Q_DEPTH + 1);

	nbbsm_pkg::cmd_t  entry_q [nbbsm_pkg::Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(nbbsm_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(nbbsm_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	`NBBSM_ASSERT_IMP(a_q_no_overflow, clk, arst_n, 1'b1, count_q <= CNT_W'(nbbsm_pkg::Q_DEPTH))
	`NBBSM_ASSERT_NXT(a_q_grow, clk, arst_n, do_push && !do_pop, count_q == $past(count_q) + CNT_W'(1))
	`NBBSM_ASSERT_NXT(a_q_shrink, clk, arst_n, do_pop && !do_push, count_q == $past(count_q) - CNT_W'(1))

endmodule

[hdl/nbbsm_back.sv]
// Map engine: bad mark store, word scan with popcount, rank narrowing, result register.
`include "nand_bad_block_skip_map_unit_defines.svh"

module nbbsm_back #(
	parameter int MAX_BLOCKS = nbbsm_pkg::DEF_MAX_BLOCKS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_pop,
	input  nbbsm_pkg::cmd_t             cmd,
	input  logic [nbbsm_pkg::CFG_W-1:0] lim,
	output logic                        res_valid,
	input  logic                        res_ready,
	output nbbsm_pkg::res_t             res
);

	localparam int EFF   = (MAX_BLOCKS < nbbsm_pkg::ADDR_SPAN) ? MAX_BLOCKS
		: nbbsm_pkg::ADDR_SPAN;
	localparam int WORDS = (EFF + nbbsm_pkg::WORD_BITS - 1) / nbbsm_pkg::WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int NW    = 1 << AW;
	localparam int WB    = nbbsm_pkg::WORD_BITS;
	localparam int BW    = nbbsm_pkg::BLK_W;
	localparam int CW    = nbbsm_pkg::CNT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WR_RD,
		ST_WR_WB,
		ST_SCAN,
		ST_NARROW,
		ST_FIN
	} st_t;

	logic [WB-1:0]   mem [NW];
	logic [NW-1:0]   wvld_q;
	logic [WB-1:0]   rdata_s1;
	logic            rvld_s1;

	st_t             state_q;
	nbbsm_pkg::cmd_t cmd_q;
	logic [AW-1:0]   rd_addr_q;
	logic            ev_vld_s1;
	logic [AW-1:0]   ev_addr_s1;
	logic [BW-1:0]   n_q;
	logic [WB-1:0]   win_q;
	logic [BW-1:0]   base_q;
	logic [2:0]      step_q;
	logic            fin_found_q;
	logic [BW-1:0]   fin_phys_q;
	logic            res_vld_q;
	nbbsm_pkg::res_t res_q;

	logic [nbbsm_pkg::CFG_W-1:0] lim_m1;
	logic [5:0]      last_w;
	logic [5:0]      last_b;
	logic [5:0]      start_w;
	logic [5:0]      start_b;
	logic [5:0]      ev_w;
	logic [WB-1:0]   word_good;
	logic [WB-1:0]   lo_mask;
	logic [WB-1:0]   hi_mask;
	logic [WB-1:0]   good;
	logic [CW-1:0]   pc;
	logic            hit;
	logic            ev_last;
	logic [5:0]      h;
	logic [WB-1:0]   low_mask;
	logic [CW-1:0]   pcl;
	logic            go_high;
	logic [BW-1:0]   base_nx;
	logic            load;
	logic            mem_we;
	logic [WB-1:0]   mem_wdata;

	assign lim_m1  = lim - nbbsm_pkg::CFG_W'(1);
	assign last_w  = lim_m1[11:6];
	assign last_b  = lim_m1[5:0];
	assign start_w = cmd_q.blk[11:6];
	assign start_b = cmd_q.blk[5:0];
	assign ev_w    = 6'(ev_addr_s1);

	// word scan: good blocks inside [start, lim) of the word just read
	assign word_good = rvld_s1 ? ~rdata_s1 : {WB{1'b1}};
	assign lo_mask   = (ev_w == start_w) ? ({WB{1'b1}} << start_b) : {WB{1'b1}};
	assign hi_mask   = (ev_w == last_w) ? ({WB{1'b1}} >> (6'd63 - last_b)) : {WB{1'b1}};
	assign good      = word_good & lo_mask & hi_mask;
	assign pc        = nbbsm_pkg::popcnt64(good);
	assign hit       = BW'(pc) > n_q;
	assign ev_last   = (ev_w == last_w);

	// narrowing: halve the window each step toward the wanted good bit
	assign h        = 6'(6'd32 >> step_q);
	assign low_mask = ~({WB{1'b1}} << h);
	assign pcl      = nbbsm_pkg::popcnt64(win_q & low_mask);
	assign go_high  = !(n_q < BW'(pcl));
	assign base_nx  = go_high ? base_q + BW'(h) : base_q;

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign load      = (state_q == ST_FIN) && (!res_vld_q || res_ready);
	assign mem_we    = (state_q == ST_WR_WB);
	assign res_valid = res_vld_q;
	assign res       = res_q;

	always_comb begin
		mem_wdata = rvld_s1 ? rdata_s1 : '0;
		mem_wdata[cmd_q.blk[5:0]] = cmd_q.mark;
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= mem[rd_addr_q];
		if (mem_we) begin
			mem[rd_addr_q] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wvld_q      <= '0;
			rvld_s1     <= 1'b0;
			cmd_q       <= '0;
			rd_addr_q   <= '0;
			ev_vld_s1   <= 1'b0;
			ev_addr_s1  <= '0;
			n_q         <= '0;
			win_q       <= '0;
			base_q      <= '0;
			step_q      <= '0;
			fin_found_q <= 1'b0;
			fin_phys_q  <= '0;
			res_vld_q   <= 1'b0;
			res_q       <= '0;
		end else begin
			rvld_s1 <= wvld_q[rd_addr_q];
			if (res_vld_q && res_ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ev_vld_s1 <= 1'b0;
					if (cmd_valid) begin
						cmd_q     <= cmd;
						rd_addr_q <= AW'(cmd.blk[11:6]);
						n_q       <= cmd.rank;
						case (cmd.kind)
							nbbsm_pkg::CMD_WRITE: begin
								state_q <= ST_WR_RD;
							end
							nbbsm_pkg::CMD_SCAN: begin
								state_q <= ST_SCAN;
							end
							default: begin
								fin_found_q <= 1'b0;
								fin_phys_q  <= '0;
								state_q     <= ST_FIN;
							end
						endcase
					end
				end
				ST_WR_RD: begin
					state_q <= ST_WR_WB;
				end
				ST_WR_WB: begin
					wvld_q[rd_addr_q] <= 1'b1;
					fin_found_q       <= 1'b1;
					fin_phys_q        <= '0;
					state_q           <= ST_FIN;
				end
				ST_SCAN: begin
					// keep one read in flight ahead of the word under test
					ev_vld_s1  <= 1'b1;
					ev_addr_s1 <= rd_addr_q;
					rd_addr_q  <= rd_addr_q + AW'(1);
					if (ev_vld_s1) begin
						if (hit) begin
							win_q     <= good;
							base_q    <= {ev_w, 6'd0};
							step_q    <= '0;
							ev_vld_s1 <= 1'b0;
							state_q   <= ST_NARROW;
						end else begin
							n_q <= n_q - BW'(pc);
							if (ev_last) begin
								fin_found_q <= 1'b0;
								fin_phys_q  <= '0;
								ev_vld_s1   <= 1'b0;
								state_q     <= ST_FIN;
							end
						end
					end
				end
				ST_NARROW: begin
					if (go_high) begin
						win_q <= win_q >> h;
						n_q   <= n_q - BW'(pcl);
					end
					base_q <= base_nx;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						fin_found_q <= 1'b1;
						fin_phys_q  <= base_nx;
						state_q     <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_vld_q || res_ready) begin
						res_vld_q   <= 1'b1;
						res_q.found <= fin_found_q;
						res_q.phys  <= fin_phys_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`NBBSM_ASSERT_IMP(a_bk_load_free, clk, arst_n, load, !res_vld_q || res_ready)
	`NBBSM_ASSERT_IMP(a_bk_rank_in_win, clk, arst_n, state_q == ST_NARROW,
		n_q < BW'(nbbsm_pkg::popcnt64(win_q)))
	`NBBSM_ASSERT_NXT(a_bk_wr_marks, clk, arst_n, mem_we, wvld_q[$past(rd_addr_q)])
	`NBBSM_ASSERT_IMP(a_bk_pop_idle, clk, arst_n, cmd_pop, !ev_vld_s1)

endmodule

[hdl/nand_bad_block_skip_map_unit.sv]
// Top level of the NAND bad block skip map: limit register and stream ports.
//
// Keeps one bad mark per NAND block, all good after reset, and serves three kinds of item:
// write a bad mark, map a logical block to the (n+1)-th good physical block, or find the
// first good block after a physical block. Every item returns exactly one result. The map
// is held as 64-bit words with one valid flag per word, so no clearing pass follows reset.
// A write reads one word, merges the mark and writes the word back. A lookup scans from w0,
// the first word touched, up to at most the last word below L, the block count in use: the
// engine tests one map word per cycle with a 64-bit popcount, then narrows to the chosen
// bit in six halving steps. A lookup that fails early (rank or start beyond the limit) and
// an unused operation skip the map store and return a not-found result. The front
// stage and a two-entry command queue take new items while the engine works.
module nand_bad_block_skip_map_unit #(
	parameter int MAX_BLOCKS = nbbsm_pkg::DEF_MAX_BLOCKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [11:0] block_number, [12] bad_mark, [15:13] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [11:0] physical_block, [15:12] zero
	output logic        m_axis_tuser,   // [0] found
	input  logic        cfg_wr_en,
	input  logic [12:0] cfg_wr_data     // blocks_in_use
);

	localparam int EFF = (MAX_BLOCKS < nbbsm_pkg::ADDR_SPAN) ? MAX_BLOCKS
		: nbbsm_pkg::ADDR_SPAN;
	localparam logic [nbbsm_pkg::CFG_W-1:0] LIM_MAX = nbbsm_pkg::CFG_W'(EFF);

	logic [nbbsm_pkg::CFG_W-1:0] lim_q;
	logic            f_push;
	logic            f_ready;
	nbbsm_pkg::cmd_t f_cmd;
	logic            q_valid;
	logic            q_pop;
	nbbsm_pkg::cmd_t q_cmd;
	nbbsm_pkg::res_t b_res;

	// saturate the block count to what the store holds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIM_MAX;
		end else if (cfg_wr_en) begin
			lim_q <= (cfg_wr_data > LIM_MAX) ? LIM_MAX : cfg_wr_data;
		end
	end

	nbbsm_front #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_blk    (s_axis_tdata[11:0]),
		.in_mark   (s_axis_tdata[12]),
		.lim       (lim_q),
		.push      (f_push),
		.push_ready(f_ready),
		.cmd       (f_cmd)
	);

	nbbsm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_ready(f_ready),
		.push_cmd  (f_cmd),
		.pop_valid (q_valid),
		.pop       (q_pop),
		.pop_cmd   (q_cmd)
	);

	nbbsm_back #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(q_valid),
		.cmd_pop  (q_pop),
		.cmd      (q_cmd),
		.lim      (lim_q),
		.res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready),
		.res      (b_res)
	);

	assign m_axis_tdata = {4'd0, b_res.phys};
	assign m_axis_tuser = b_res.found;

endmodule

[dv/nand_bad_block_skip_map_unit_test.sv]
// Testbench for the NAND bad block skip map: directed and random item streams against a predictor.
module nand_bad_block_skip_map_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STORE_BLOCKS = 4096;
	localparam int IDLE_PCT = 35;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // [11:0] block_number, [12] bad_mark, [15:13] zero
	logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;        // [11:0] physical_block, [15:12] zero
	logic        m_axis_tuser;        // [0] found
	logic        cfg_wr_en = 1'b0;
	logic [12:0] cfg_wr_data = '0;    // blocks_in_use

	// predictor state
	logic        bad_marks [STORE_BLOCKS];
	logic [12:0] blocks_in_use_q = 13'd4096;
	nbbsm_pkg::res_t pending_results [$];

	int  mismatch_count = 0;
	int  stall_cycles = 0;
	bit  no_idle = 1'b0;

	nand_bad_block_skip_map_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int lookup_span();
		return (blocks_in_use_q > 13'd4096) ? STORE_BLOCKS : int'(blocks_in_use_q);
	endfunction

	// Apply one item to the shadow map and return the result it must produce.
	function automatic nbbsm_pkg::res_t skip_map_predict(input logic [1:0] op,
			input logic [11:0] blk, input logic mark);
		nbbsm_pkg::res_t r;
		int   lim;
		int   good_seen;
		r = '0;
		lim = lookup_span();
		good_seen = 0;
		case (op)
			nbbsm_pkg::OP_WRITE: begin
				bad_marks[blk] = mark;
				r.found = 1'b1;
			end
			nbbsm_pkg::OP_MAP: begin
				if (int'(blk) < lim) begin
					for (int p = 0; p < lim; p++) begin
						if (!bad_marks[p]) begin
							if (good_seen == int'(blk)) begin
								r.found = 1'b1;
								r.phys = 12'(p);
								break;
							end
							good_seen++;
						end
					end
				end
			end
			nbbsm_pkg::OP_NEXT: begin
				for (int p = int'(blk) + 1; p < lim; p++) begin
					if (!bad_marks[p]) begin
						r.found = 1'b1;
						r.phys = 12'(p);
						break;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic send_item(input logic [1:0] op, input logic [11:0] blk, input logic mark);
		if (!no_idle) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, mark, blk};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(skip_map_predict(op, blk, mark));
	endtask

	// Drop valid, let every item finish, then write the limit register.
	task automatic write_blocks_in_use(input logic [12:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		blocks_in_use_q = value;
	endtask

	task automatic send_random_item(input int lim);
		logic [1:0]  op;
		logic [11:0] blk;
		logic        mark;
		int          sel;
		int          span;
		sel = $urandom_range(99);
		span = (lim > 0) ? lim : 16;
		mark = 1'($urandom_range(1));
		if ($urandom_range(9) == 0)
			blk = 12'($urandom);
		else
			blk = 12'($urandom_range(span - 1));
		if (sel < 40)
			op = nbbsm_pkg::OP_WRITE;
		else if (sel < 72)
			op = nbbsm_pkg::OP_MAP;
		else if (sel < 94)
			op = nbbsm_pkg::OP_NEXT;
		else
			op = OP_UNUSED;
		send_item(op, blk, mark);
	endtask

	task automatic test_edges_at_reset();
		send_item(nbbsm_pkg::OP_MAP, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_MAP, 12'd4095, 1'b0);
		send_item(nbbsm_pkg::OP_NEXT, 12'd4095, 1'b0);
		send_item(nbbsm_pkg::OP_NEXT, 12'd0, 1'b1);
		send_item(nbbsm_pkg::OP_NEXT, 12'd4094, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd0, 1'b1);
		send_item(nbbsm_pkg::OP_MAP, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_MAP, 12'd4095, 1'b1);
		send_item(nbbsm_pkg::OP_WRITE, 12'd4095, 1'b1);
		send_item(nbbsm_pkg::OP_NEXT, 12'd4094, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd4095, 1'b0);
		send_item(OP_UNUSED, 12'd4095, 1'b1);
		send_item(nbbsm_pkg::OP_WRITE, 12'd0, 1'b0);
	endtask

	task automatic test_limit_register();
		write_blocks_in_use(13'd1);
		send_item(nbbsm_pkg::OP_MAP, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_MAP, 12'd1, 1'b0);
		send_item(nbbsm_pkg::OP_NEXT, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd4095, 1'b1);
		send_item(nbbsm_pkg::OP_WRITE, 12'd0, 1'b1);
		send_item(nbbsm_pkg::OP_MAP, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd0, 1'b0);
		write_blocks_in_use(13'd0);
		send_item(nbbsm_pkg::OP_MAP, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_NEXT, 12'd0, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd5, 1'b1);
		write_blocks_in_use(13'd8191);
		send_item(nbbsm_pkg::OP_MAP, 12'd4093, 1'b0);
		send_item(nbbsm_pkg::OP_NEXT, 12'd4094, 1'b0);
		write_blocks_in_use(13'd4097);
		send_item(nbbsm_pkg::OP_NEXT, 12'd4095, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd4095, 1'b0);
		send_item(nbbsm_pkg::OP_WRITE, 12'd5, 1'b0);
	endtask

	task automatic test_random_small_limits();
		int lim;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: lim = 2;
				1: lim = 64;
				2: lim = 65;
				default: lim = $urandom_range(300, 3);
			endcase
			write_blocks_in_use(13'(lim));
			repeat (115) send_random_item(lim);
		end
	endtask

	task automatic test_random_large_limits();
		write_blocks_in_use(13'd4096);
		repeat (220) send_random_item(STORE_BLOCKS);
		write_blocks_in_use(13'($urandom_range(4095, 2000)));
		repeat (80) send_random_item(lookup_span());
		write_blocks_in_use(13'($urandom_range(8191, 4097)));
		repeat (60) send_random_item(STORE_BLOCKS);
	endtask

	task automatic test_back_to_back();
		write_blocks_in_use(13'd96);
		no_idle = 1'b1;
		repeat (180) send_random_item(96);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		no_idle = 1'b0;
	endtask

	// Result checker and receiver backpressure.
	always @(posedge clk) begin : result_check
		nbbsm_pkg::res_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: found=%0b tdata=%h", m_axis_tuser, m_axis_tdata);
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tuser !== want.found) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("found mismatch: expected %0b actual %0b",
								want.found, m_axis_tuser);
					end
					if (m_axis_tdata !== {4'b0000, want.phys}) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("physical_block mismatch: expected %h actual %h",
								{4'b0000, want.phys}, m_axis_tdata);
					end
				end
			end
			m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("nand_bad_block_skip_map_unit_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < STORE_BLOCKS; i++) bad_marks[i] = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edges_at_reset();
		test_limit_register();
		test_random_small_limits();
		test_random_large_limits();
		test_back_to_back();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("nand_bad_block_skip_map_unit_test: PASS");
		else
			$display("nand_bad_block_skip_map_unit_test: FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hdl
hdl/nbbsm_pkg.sv
hdl/nbbsm_front.sv
hdl/nbbsm_queue.sv
hdl/nbbsm_back.sv
hdl/nand_bad_block_skip_map_unit.sv
dv/nand_bad_block_skip_map_unit_test.sv
